// ===== rtl/sma_pkg.sv =====
package sma_pkg;

  // default build values
  localparam int DEF_MAX_WINDOW  = 64;
  localparam int DEF_SAMPLE_BITS = 16;

  // register port width and window length after reset
  localparam int WIN_REG_W    = 7;
  localparam int RESET_WINDOW = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPD,
    ST_DIV,
    ST_WAIT
  } sma_state_t;

  // per-beat control shared by both channel lanes
  typedef struct packed {
    logic clr;        // zero the running sum
    logic load;       // capture the incoming sample
    logic upd;        // write history, update running sum
    logic evict;      // oldest sample leaves the window
    logic div_start;  // start the mean division
  } sma_lane_ctl_t;

endpackage

// ===== rtl/sma_ram.sv =====
module sma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sma_div.sv =====
module sma_div #(
  parameter int SUM_W       = 22,
  parameter int WIN_W       = 7,
  parameter int SAMPLE_BITS = 16,
  localparam int CW = $clog2(SUM_W + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [SUM_W-1:0]       dividend,
  input  logic [WIN_W-1:0]       divisor,
  output logic                   idle,
  output logic [SAMPLE_BITS-1:0] quotient
);

  logic             busy_r, busy_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic [SUM_W-1:0] dq_r, dq_nxt;
  logic [WIN_W-1:0] rem_r, rem_nxt;
  logic [WIN_W-1:0] dvs_r, dvs_nxt;
  logic [WIN_W:0]   rem_sh;
  logic [WIN_W:0]   rem_sub;
  logic             ge;
  logic [SUM_W-1:0] q_signed;

  // restoring division on the magnitude, one quotient bit a cycle
  assign rem_sh  = {rem_r, dq_r[SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(SUM_W);
      neg_nxt  = dividend[SUM_W-1];
      dq_nxt   = dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[SUM_W-2:0], ge};
      rem_nxt = ge ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign q_signed = neg_r ? (SUM_W'(0) - dq_r) : dq_r;
  assign quotient = q_signed[SAMPLE_BITS-1:0];
  assign idle     = !busy_r;

endmodule

// ===== rtl/sma_lane.sv =====
module sma_lane #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int AW          = 6,
  parameter int WIN_W       = 7,
  parameter int SUM_W       = 22
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sma_pkg::sma_lane_ctl_t ctl,
  input  logic [AW-1:0]          addr,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  input  logic [WIN_W-1:0]       win,
  output logic                   div_idle,
  output logic [SAMPLE_BITS-1:0] average
);

  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SUM_W-1:0]       new_ext;
  logic [SUM_W-1:0]       old_ext;

  sma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (ctl.upd),
    .waddr (addr),
    .wdata (sample_r),
    .raddr (addr),
    .rdata (old_sample)
  );

  assign new_ext = {{(SUM_W - SAMPLE_BITS){sample_r[SAMPLE_BITS-1]}}, sample_r};
  assign old_ext = {{(SUM_W - SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample};

  always_comb begin
    sum_nxt = sum_r;
    if (ctl.clr) begin
      sum_nxt = '0;
    end else if (ctl.upd) begin
      sum_nxt = sum_r + new_ext - (ctl.evict ? old_ext : SUM_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
    if (ctl.load) begin
      sample_r <= sample_in;
    end
  end

  sma_div #(
    .SUM_W       (SUM_W),
    .WIN_W       (WIN_W),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (sum_r),
    .divisor  (win),
    .idle     (div_idle),
    .quotient (average)
  );

endmodule

// ===== rtl/stereo_moving_average.sv =====
// stereo moving average over the newest window_length frames
//
// in_*   : one stereo frame per beat; in_tuser set clears the window and
//          sums before the frame is taken, so it starts a new window
// out_*  : per-channel mean, truncated toward zero; one beat per input frame
//          once the window is full, none while it is still filling
// cfg_*  : window length write, clamped to 1..MAX_WINDOW, also clears the window
//
// each frame runs through both channel lanes side by side: history read,
// sum update, then a restoring divider giving one quotient bit a cycle.
// a frame that fills no window goes back to idle after the sum update; one
// that yields a mean waits on the divider. the next frame is taken as soon as
// the mean has moved into the output register, even while that beat still
// waits on out_tready.
//
// reset: window length 4, empty window, no output pending. history memories
// are not cleared; entries are only read after being written.
// a stalled receiver holds the output beat; the block stops taking frames only
// once a second mean is ready and the output register is still occupied
module stereo_moving_average #(
  parameter int MAX_WINDOW  = sma_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = sma_pkg::DEF_SAMPLE_BITS,
  localparam int TD_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: left_sample, right_sample, zero padding
  input  logic [TD_W-1:0]               in_tdata,
  // in_tuser: start_of_stream
  input  logic                          in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // out_tdata: left_average, right_average, zero padding
  output logic [TD_W-1:0]               out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_wen,
  input  logic [sma_pkg::WIN_REG_W-1:0] cfg_wdata
);

  localparam int AW       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_W    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W    = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int WIN_INIT = (sma_pkg::RESET_WINDOW > MAX_WINDOW) ? MAX_WINDOW
                                                                  : sma_pkg::RESET_WINDOW;

  sma_pkg::sma_state_t    state_r, state_nxt;
  sma_pkg::sma_lane_ctl_t lane_ctl;

  logic [WIN_W-1:0] win_r;
  logic [WIN_W-1:0] frames_r;
  logic [AW-1:0]    wpos_r;
  logic [AW-1:0]    apos_r;
  logic             evict_r;
  logic             result_r;

  logic             accept;
  logic [WIN_W-1:0] frames_eff;
  logic [AW-1:0]    pos_eff;
  logic [WIN_W-1:0] pos_inc;
  logic             evict_now;
  logic [WIN_W-1:0] frames_new;
  logic [31:0]      cfg_ext;
  logic [WIN_W-1:0] win_wr;

  logic                   idle_l, idle_r;
  logic [SAMPLE_BITS-1:0] avg_l, avg_r;
  logic                   out_load;
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_left_r, out_right_r;

  assign accept = in_tvalid && in_tready;

  // start flag restarts the window for this very frame
  assign frames_eff = in_tuser ? '0 : frames_r;
  assign pos_eff    = in_tuser ? '0 : wpos_r;
  assign evict_now  = frames_eff >= win_r;
  assign frames_new = evict_now ? frames_eff : frames_eff + WIN_W'(1);
  assign pos_inc    = WIN_W'(pos_eff) + WIN_W'(1);

  // clamp the written length into 1..MAX_WINDOW
  assign cfg_ext = 32'(cfg_wdata);
  always_comb begin
    if (cfg_ext == 32'd0) begin
      win_wr = WIN_W'(1);
    end else if (cfg_ext > 32'(MAX_WINDOW)) begin
      win_wr = WIN_W'(MAX_WINDOW);
    end else begin
      win_wr = cfg_ext[WIN_W-1:0];
    end
  end

  // sequencer: read history, update sums, divide, hand over
  always_comb begin
    state_nxt          = state_r;
    in_tready          = 1'b0;
    out_load           = 1'b0;
    lane_ctl.clr       = cfg_wen;
    lane_ctl.load      = 1'b0;
    lane_ctl.upd       = 1'b0;
    lane_ctl.evict     = evict_r;
    lane_ctl.div_start = 1'b0;
    case (state_r)
      sma_pkg::ST_IDLE: begin
        in_tready     = 1'b1;
        lane_ctl.load = in_tvalid;
        if (in_tvalid) begin
          lane_ctl.clr = cfg_wen || in_tuser;
          state_nxt    = sma_pkg::ST_READ;
        end
      end
      sma_pkg::ST_READ: begin
        state_nxt = sma_pkg::ST_UPD;
      end
      sma_pkg::ST_UPD: begin
        lane_ctl.upd = 1'b1;
        state_nxt    = result_r ? sma_pkg::ST_DIV : sma_pkg::ST_IDLE;
      end
      sma_pkg::ST_DIV: begin
        lane_ctl.div_start = 1'b1;
        state_nxt          = sma_pkg::ST_WAIT;
      end
      sma_pkg::ST_WAIT: begin
        if (idle_l && (!out_valid_r || out_tready)) begin
          out_load  = 1'b1;
          state_nxt = sma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sma_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sma_pkg::ST_IDLE;
      win_r       <= WIN_W'(WIN_INIT);
      frames_r    <= '0;
      wpos_r      <= '0;
      evict_r     <= 1'b0;
      result_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wen) begin
        win_r    <= win_wr;
        frames_r <= '0;
        wpos_r   <= '0;
      end else if (accept) begin
        frames_r <= frames_new;
        wpos_r   <= (pos_inc >= win_r) ? '0 : pos_inc[AW-1:0];
        evict_r  <= evict_now;
        result_r <= frames_new >= win_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      apos_r <= pos_eff;
    end
    if (out_load) begin
      out_left_r  <= avg_l;
      out_right_r <= avg_r;
    end
  end

  // channel lanes
  sma_lane #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .AW          (AW),
    .WIN_W       (WIN_W),
    .SUM_W       (SUM_W)
  ) u_lane_l (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (lane_ctl),
    .addr      (apos_r),
    .sample_in (in_tdata[SAMPLE_BITS-1:0]),
    .win       (win_r),
    .div_idle  (idle_l),
    .average   (avg_l)
  );

  sma_lane #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .AW          (AW),
    .WIN_W       (WIN_W),
    .SUM_W       (SUM_W)
  ) u_lane_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (lane_ctl),
    .addr      (apos_r),
    .sample_in (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .win       (win_r),
    .div_idle  (idle_r),
    .average   (avg_r)
  );

  // merge both lane means into one beat
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TD_W'({out_right_r, out_left_r});

  // fill count never passes the window length
  a_frames_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    frames_r <= win_r)
    else $error("frame count beyond window length");

  // write position stays inside the window
  a_wpos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    WIN_W'(wpos_r) < win_r)
    else $error("write position outside window");

  // both lane dividers run in lock step
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    idle_l == idle_r)
    else $error("lane dividers out of step");

  // a frame is only taken while no division is in flight
  a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> idle_l)
    else $error("frame taken during division");

  // a frame that fills no window returns straight to idle
  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sma_pkg::ST_UPD && !result_r) |=> state_r == sma_pkg::ST_IDLE)
    else $error("frame without result did not finish");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  localparam int WIN_MAX = sma_pkg::DEF_MAX_WINDOW;
  localparam int CFG_W   = sma_pkg::WIN_REG_W;
  // longest the block works on one frame, with margin
  localparam int SETTLE_CYCLES = 64;

  // one stereo pair as it sits on tdata: left in the low half
  typedef struct packed {
    logic signed [15:0] right;
    logic signed [15:0] left;
  } stereo_t;

  // directed stimulus row; typed_mean is used only where has_typed is set
  typedef struct packed {
    bit      has_typed;
    bit      restart;
    stereo_t frame;
    stereo_t typed_mean;
  } frame_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [31:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_wen = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  stereo_moving_average dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // window predictor: own copy of history, sums, fill count and write pointer
  // ---------------------------------------------------------------------------
  logic signed [15:0] left_hist  [WIN_MAX];
  logic signed [15:0] right_hist [WIN_MAX];
  logic signed [21:0] left_sum, right_sum;
  int unsigned frames_held, write_ptr, window_len;

  stereo_t pending_means[$];   // means still owed by the block, oldest first
  int      mismatches = 0;

  function automatic void clear_window();
    left_sum    = '0;
    right_sum   = '0;
    frames_held = 0;
    write_ptr   = 0;
  endfunction

  // register write: clamped to 1..max window, always empties the window
  function automatic void set_window_len(logic [CFG_W-1:0] v);
    if (v < 1)
      window_len = 1;
    else if (v > WIN_MAX)
      window_len = WIN_MAX;
    else
      window_len = v;
    clear_window();
  endfunction

  // mean truncated toward zero, same as signed integer division
  function automatic logic signed [15:0] window_mean(logic signed [21:0] s, int unsigned n);
    int q;
    q = int'(s) / int'(n);
    return q[15:0];
  endfunction

  // take one frame into the window; returns 1 when a mean comes out
  function automatic bit slide_window(stereo_t f, bit restart, output stereo_t mean);
    if (restart)
      clear_window();
    if (frames_held >= window_len) begin
      left_sum  = left_sum  - left_hist[write_ptr];
      right_sum = right_sum - right_hist[write_ptr];
    end else begin
      frames_held++;
    end
    left_hist[write_ptr]  = f.left;
    right_hist[write_ptr] = f.right;
    left_sum  = left_sum  + f.left;
    right_sum = right_sum + f.right;
    write_ptr++;
    if (write_ptr >= window_len)
      write_ptr = 0;
    mean.left  = window_mean(left_sum, window_len);
    mean.right = window_mean(right_sum, window_len);
    return frames_held >= window_len;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of random length, random gaps, noise on tdata while idle
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_frame(stereo_t f, bit restart, bit has_typed, stereo_t typed_mean);
    int      gap;
    stereo_t mean;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= $urandom;
        in_tuser  <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= f;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    if (slide_window(f, restart, mean))
      pending_means.push_back(has_typed ? typed_mean : mean);
  endtask

  // drop valid and hold off until the block has delivered every owed mean
  task automatic drain_means();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_means.size() != 0) @(posedge clk);
  endtask

  // register write, only with the block idle: frames that gave no mean may
  // still be in flight, so let the pipeline settle first
  task automatic write_window_len(logic [CFG_W-1:0] v);
    drain_means();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    cfg_wdata <= CFG_W'($urandom);
    set_window_len(v);
  endtask

  // mostly random samples, full scale now and then; a hot phase sits on one value
  function automatic logic signed [15:0] pick_sample(bit hot, logic signed [15:0] hot_val);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (hot && r < 6)
      return hot_val;
    case (r)
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: ready pattern switches between always ready, random and periodic
  // ---------------------------------------------------------------------------
  int unsigned ready_mode = 0;
  int unsigned ready_cnt  = 0;

  always @(posedge clk) begin
    ready_cnt <= ready_cnt + 1;
    if (ready_cnt % 256 == 255)
      ready_mode <= $urandom_range(0, 2);
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ((ready_cnt % 16) < 5);
    endcase
  end

  // ---------------------------------------------------------------------------
  // output check: every beat against the oldest owed mean
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    stereo_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected output beat left=%0d right=%0d",
                 $time, got.left, got.right);
        mismatches++;
      end else begin
        want = pending_means.pop_front();
        if (got.left !== want.left) begin
          $display("%0t: left_average expected %0d got %0d", $time, want.left, got.left);
          mismatches++;
        end
        if (got.right !== want.right) begin
          $display("%0t: right_average expected %0d got %0d", $time, want.right, got.right);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed rows, run at the reset window length of 4
  // ---------------------------------------------------------------------------
  localparam int N_ROWS = 20;
  localparam frame_row_t DIRECTED_ROWS [N_ROWS] = '{
    // window fills with full-scale samples, fourth frame gives the extremes
    '{1'b0, 1'b0, {16'sh8000, 16'sh7fff}, 32'h0},
    '{1'b0, 1'b0, {16'sh8000, 16'sh7fff}, 32'h0},
    '{1'b0, 1'b0, {16'sh8000, 16'sh7fff}, 32'h0},
    '{1'b1, 1'b0, {16'sh8000, 16'sh7fff}, {16'sh8000, 16'sh7fff}},
    '{1'b0, 1'b0, {16'sh7fff, 16'sh8000}, 32'h0},
    // start flag mid stream: frame counts as the first of a new window
    '{1'b0, 1'b1, {-16'sd1, 16'sd1}, 32'h0},
    '{1'b0, 1'b0, {-16'sd2, 16'sd2}, 32'h0},
    '{1'b0, 1'b0, {-16'sd3, 16'sd3}, 32'h0},
    '{1'b1, 1'b0, {-16'sd4, 16'sd4}, {-16'sd2, 16'sd2}},
    // small negative sum truncates to zero, not to -1
    '{1'b0, 1'b1, {16'sd1, -16'sd1}, 32'h0},
    '{1'b0, 1'b0, 32'h0, 32'h0},
    '{1'b0, 1'b0, 32'h0, 32'h0},
    '{1'b1, 1'b0, 32'h0, 32'h0},
    '{1'b0, 1'b0, {16'sd7, -16'sd7}, 32'h0},
    // most-negative samples with one full-scale positive frame among them
    '{1'b0, 1'b1, {16'sh8000, 16'sh8000}, 32'h0},
    '{1'b0, 1'b0, {16'sh7fff, 16'sh7fff}, 32'h0},
    '{1'b0, 1'b0, {16'sh8000, 16'sh8000}, 32'h0},
    '{1'b0, 1'b0, {16'sh8000, 16'sh8000}, 32'h0},
    // alternating bit patterns on both channels
    '{1'b0, 1'b0, {16'shaaaa, 16'sh5555}, 32'h0},
    '{1'b0, 1'b0, {16'sh5555, 16'shaaaa}, 32'h0}
  };

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] phase_len [9];
    int unsigned      n_frames, pause_at, eff_len;
    bit               hot;
    stereo_t          hot_val, f;

    window_len = sma_pkg::RESET_WINDOW;
    clear_window();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_ROWS; i++)
      send_frame(DIRECTED_ROWS[i].frame, DIRECTED_ROWS[i].restart,
                 DIRECTED_ROWS[i].has_typed, DIRECTED_ROWS[i].typed_mean);

    // register settings: below range, both ends, above range, and random ones
    phase_len = '{7'd0, 7'd64, 7'd3, 7'd127, 7'd2, 7'd65, 7'd1,
                  7'($urandom_range(1, 64)), 7'($urandom_range(0, 127))};

    foreach (phase_len[p]) begin
      write_window_len(phase_len[p]);
      eff_len  = window_len;
      n_frames = (eff_len > 32) ? 80 : 40;
      pause_at = $urandom_range(0, n_frames - 1);
      hot      = ($urandom_range(0, 2) == 0);
      hot_val  = {pick_sample(1'b0, 16'sh0), pick_sample(1'b0, 16'sh0)};
      for (int k = 0; k < n_frames; k++) begin
        f.left  = pick_sample(hot, hot_val.left);
        f.right = pick_sample(hot, hot_val.right);
        // restarts rare on long windows so the window still fills
        send_frame(f, $urandom_range(0, (eff_len > 32) ? 199 : 15) == 0, 1'b0, 32'h0);
        if (k == pause_at)
          drain_means();
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  // watchdog, well beyond the slowest correct run
  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sma_pkg.sv
rtl/sma_ram.sv
rtl/sma_div.sv
rtl/sma_lane.sv
rtl/stereo_moving_average.sv
tb/tb_top.sv
